// File: src/wcf_pkg.sv
// shared constants and codes for the weighted concordance fraction block
`timescale 1ns / 1ps
package wcf_pkg;
    localparam int MAX_OBS_DEF = 64;
    localparam int GRP_W       = 32;
    localparam int WGT_W       = 24;
    localparam int TOL_W       = 31;
    localparam int CNT_CFG_W   = 7;
    localparam int IDX_W       = 6;
    localparam int FRAC_W      = 17;
    localparam int FRAC_SH     = 16;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 56;
    localparam int FUNC_W      = 2;
    localparam int CODE_W      = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_OBS  = 2'd0,
        FUNC_LOAD_CODE = 2'd1,
        FUNC_QUERY     = 2'd2,
        FUNC_NONE      = 2'd3
    } t_func;

    localparam logic [CODE_W-1:0] CODE_DISC = 2'd0;
    localparam logic [CODE_W-1:0] CODE_TIED = 2'd1;
    localparam logic [CODE_W-1:0] CODE_CONC = 2'd2;
    localparam logic [CODE_W-1:0] CODE_INV  = 2'd3;

    localparam logic REG_OBS_COUNT = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;
endpackage

// File: src/wcf_mem.sv
// observation store and pairwise code store, synchronous read
`timescale 1ns / 1ps
module wcf_mem #(
    parameter int MAX_OBS = wcf_pkg::MAX_OBS_DEF,
    parameter int IW      = $clog2(MAX_OBS),
    parameter int CAW     = $clog2(MAX_OBS * MAX_OBS),
    parameter int OW      = wcf_pkg::GRP_W + wcf_pkg::WGT_W
) (
    input  logic                      i_clk,
    input  logic                      i_obs_we,
    input  logic [IW-1:0]             i_obs_waddr,
    input  logic [OW-1:0]             i_obs_wdata,
    input  logic [IW-1:0]             i_obs_raddr,
    output logic [OW-1:0]             o_obs_rdata,
    input  logic                      i_code_we,
    input  logic [CAW-1:0]            i_code_waddr,
    input  logic [wcf_pkg::CODE_W-1:0] i_code_wdata,
    input  logic [CAW-1:0]            i_code_raddr,
    output logic [wcf_pkg::CODE_W-1:0] o_code_rdata
);
    logic [OW-1:0]              r_obs_mem  [MAX_OBS];
    logic [wcf_pkg::CODE_W-1:0] r_code_mem [MAX_OBS*MAX_OBS];

    always_ff @(posedge i_clk) begin
        if (i_obs_we) begin
            r_obs_mem[i_obs_waddr] <= i_obs_wdata;
        end
        o_obs_rdata <= r_obs_mem[i_obs_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_code_we) begin
            r_code_mem[i_code_waddr] <= i_code_wdata;
        end
        o_code_rdata <= r_code_mem[i_code_raddr];
    end
endmodule

// File: src/wcf_div.sv
// rounded share divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wcf_div #(
    parameter int SW = 31
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [SW-1:0]              i_part,
    input  logic [SW-1:0]              i_total,
    output logic                       o_done,
    output logic [wcf_pkg::FRAC_W-1:0] o_quot
);
    localparam int QW = wcf_pkg::FRAC_W;
    localparam int NW = SW + QW;
    localparam int CW = $clog2(QW + 1);

    logic [NW-1:0] w_num;
    logic [SW:0]   w_trial;
    logic          w_ge;
    logic [SW-1:0] r_rem, r_den;
    logic [QW-1:0] r_low;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    assign w_num   = {i_part, {wcf_pkg::FRAC_SH{1'b0}}} + NW'(i_total >> 1);
    assign w_trial = {r_rem, r_low[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
                r_rem  <= w_num[NW-1:QW];
                r_low  <= w_num[QW-1:0];
                r_den  <= i_total;
            end else if (r_busy) begin
                r_rem  <= w_ge ? SW'(w_trial - {1'b0, r_den}) : SW'(w_trial);
                o_quot <= {o_quot[QW-2:0], w_ge};
                r_low  <= {r_low[QW-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
endmodule

// File: src/weighted_concordance_fractions.sv
// top level: loads, row walk over the stores, share division
//
// channel   dir  handshake                      payload
// s         in   i_s_tvalid / o_s_tready        i_s_tdata, i_s_tuser (func)
// m         out  o_m_tvalid / i_m_tready        o_m_tdata, o_m_tuser (no_weight)
// cfg       in   i_cfg_we                       i_cfg_addr, i_cfg_wdata
//
// a query does one read of the row, then one store read per observation through
// a three-stage pipe, then 17 divider steps; when the total weight is zero the
// result goes out without the divider steps.
// reset clears control and tolerance, sets obs_count to 1; stores stay unknown until loaded.
// a finished result waits in the output register while loads still go in.
`timescale 1ns / 1ps
module weighted_concordance_fractions #(
    parameter int MAX_OBS = wcf_pkg::MAX_OBS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // index_a[5:0], index_b[11:6], group_value[43:12], weight_value[67:44],
    // pair_code[69:68], zero fill
    input  logic [wcf_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // func[1:0]
    input  logic [wcf_pkg::FUNC_W-1:0]     i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // concordant_frac[16:0], discordant_frac[33:17], tied_frac[50:34], zero fill
    output logic [wcf_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // no_weight[0]
    output logic        o_m_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [wcf_pkg::TOL_W-1:0]      i_cfg_wdata
);
    localparam int IW  = $clog2(MAX_OBS);
    localparam int CAW = $clog2(MAX_OBS * MAX_OBS);
    localparam int CW  = $clog2(MAX_OBS + 1);
    localparam int GW  = wcf_pkg::GRP_W;
    localparam int WW  = wcf_pkg::WGT_W;
    localparam int OW  = GW + WW;
    localparam int SW  = WW + CW;
    localparam int XW  = GW + 2;
    localparam int FW  = wcf_pkg::FRAC_W;

    typedef enum logic [2:0] {S_IDLE, S_ROW, S_GI, S_WALK, S_DIV, S_OUT} t_state;

    t_state r_state;
    logic [wcf_pkg::CNT_CFG_W-1:0] r_obs_count;
    logic [wcf_pkg::TOL_W-1:0]     r_tol;

    logic [IW-1:0]  w_a, w_b;
    logic           w_a_ok, w_b_ok, w_acc;
    wcf_pkg::t_func w_func;
    logic [IW-1:0]  r_a;
    logic [CAW-1:0] r_row_base, r_jb, r_jb1;
    logic [CW-1:0]  r_n, r_cnt;
    logic [IW-1:0]  r_j1;
    logic           r_v1, r_v2, r_use2, r_zero, r_start;
    logic [WW-1:0]  r_w2;
    logic signed [XW-1:0] r_gi;
    logic [SW-1:0]  r_conc, r_disc, r_tied, r_total;

    logic [IW-1:0]  w_obs_raddr;
    logic [OW-1:0]  w_obs_rdata;
    logic [CAW-1:0] w_code_raddr;
    logic [wcf_pkg::CODE_W-1:0] w_code_rdata;
    logic signed [XW-1:0] w_gj_tol, w_gj, w_gi_tol;
    logic           w_fwd, w_back, w_issue;
    logic [FW-1:0]  w_q_conc, w_q_disc, w_q_tied;
    logic           w_done, w_done1, w_done2;

    assign w_func = wcf_pkg::t_func'(i_s_tuser);
    assign w_a    = IW'(i_s_tdata[5:0]);
    assign w_b    = IW'(i_s_tdata[11:6]);
    assign w_a_ok = 32'(i_s_tdata[5:0]) < MAX_OBS;
    assign w_b_ok = 32'(i_s_tdata[11:6]) < MAX_OBS;
    assign w_acc  = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    wcf_mem #(.MAX_OBS(MAX_OBS), .IW(IW), .CAW(CAW), .OW(OW)) u_mem (
        .i_clk        (i_clk),
        .i_obs_we     (w_acc && w_func == wcf_pkg::FUNC_LOAD_OBS && w_a_ok),
        .i_obs_waddr  (w_a),
        .i_obs_wdata  ({i_s_tdata[67:44], i_s_tdata[43:12]}),
        .i_obs_raddr  (w_obs_raddr),
        .o_obs_rdata  (w_obs_rdata),
        .i_code_we    (w_acc && w_func == wcf_pkg::FUNC_LOAD_CODE && w_a_ok && w_b_ok),
        .i_code_waddr (CAW'(CAW'(w_a) * CAW'(MAX_OBS) + CAW'(w_b))),
        .i_code_wdata (i_s_tdata[69:68]),
        .i_code_raddr (w_code_raddr),
        .o_code_rdata (w_code_rdata)
    );

    // stage 1: compare against the row and pick the code entry
    assign w_issue     = (r_state == S_WALK) && (r_cnt < r_n);
    assign w_obs_raddr = (r_state == S_ROW) ? r_a : r_cnt[IW-1:0];
    assign w_gj        = XW'(signed'(w_obs_rdata[GW-1:0]));
    assign w_gj_tol    = w_gj + signed'(XW'(r_tol));
    assign w_gi_tol    = r_gi + signed'(XW'(r_tol));
    assign w_fwd       = r_gi > w_gj_tol;
    assign w_back      = w_gj > w_gi_tol;
    assign w_code_raddr = w_fwd ? CAW'(r_row_base + CAW'(r_j1)) : CAW'(r_jb1 + CAW'(r_a));

    wcf_div #(.SW(SW)) u_div_conc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_part(r_conc), .i_total(r_total), .o_done(w_done), .o_quot(w_q_conc)
    );
    wcf_div #(.SW(SW)) u_div_disc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_part(r_disc), .i_total(r_total), .o_done(w_done1), .o_quot(w_q_disc)
    );
    wcf_div #(.SW(SW)) u_div_tied (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_part(r_tied), .i_total(r_total), .o_done(w_done2), .o_quot(w_q_tied)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_count <= wcf_pkg::CNT_CFG_W'(1);
            r_tol       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                wcf_pkg::REG_OBS_COUNT: r_obs_count <= i_cfg_wdata[wcf_pkg::CNT_CFG_W-1:0];
                wcf_pkg::REG_TOLERANCE: r_tol       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_start    <= 1'b0;
            o_m_tvalid <= 1'b0;
        end else begin
            r_start <= (r_state == S_WALK) && !w_issue && !r_v1 && !r_v2 && (r_total != '0);
            if (o_m_tvalid && i_m_tready && r_state != S_OUT) begin
                o_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && w_func == wcf_pkg::FUNC_QUERY) begin
                        r_a        <= w_a;
                        r_row_base <= CAW'(CAW'(w_a) * CAW'(MAX_OBS));
                        if (!w_a_ok) begin
                            r_n <= '0;
                        end else if (32'(r_obs_count) > MAX_OBS) begin
                            r_n <= CW'(MAX_OBS);
                        end else begin
                            r_n <= CW'(r_obs_count);
                        end
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_state <= S_GI;
                end
                S_GI: begin
                    r_gi    <= XW'(signed'(w_obs_rdata[GW-1:0]));
                    r_cnt   <= '0;
                    r_jb    <= '0;
                    r_conc  <= '0;
                    r_disc  <= '0;
                    r_tied  <= '0;
                    r_total <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_v1 <= w_issue;
                    if (w_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_jb  <= CAW'(r_jb + CAW'(MAX_OBS));
                    end
                    r_j1   <= r_cnt[IW-1:0];
                    r_jb1  <= r_jb;
                    r_v2   <= r_v1;
                    r_w2   <= w_obs_rdata[OW-1:GW];
                    r_use2 <= w_fwd || w_back;
                    if (r_v2) begin
                        r_total <= r_total + SW'(r_w2);
                        if (r_use2) begin
                            case (w_code_rdata)
                                wcf_pkg::CODE_CONC: r_conc <= r_conc + SW'(r_w2);
                                wcf_pkg::CODE_DISC: r_disc <= r_disc + SW'(r_w2);
                                wcf_pkg::CODE_TIED: r_tied <= r_tied + SW'(r_w2);
                                default: ;
                            endcase
                        end
                    end
                    if (!w_issue && !r_v1 && !r_v2) begin
                        r_zero <= (r_total == '0);
                        if (r_total == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_m_tvalid || i_m_tready) begin
                        o_m_tvalid <= 1'b1;
                        o_m_tuser  <= r_zero;
                        o_m_tdata  <= r_zero ? '0 :
                            {5'd0, w_q_tied, w_q_disc, w_q_conc};
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (w_done1 && w_done2 && r_state == S_DIV))
        else $error("divider lanes out of step");
    a_share_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !r_start) |-> (w_q_conc <= FW'(65536) && w_q_disc <= FW'(65536)
                                  && w_q_tied <= FW'(65536)))
        else $error("share above one");
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (SW'(r_conc + r_disc) <= r_total && r_tied <= r_total))
        else $error("partial sum exceeds total");
    a_pipe_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> r_state == S_WALK)
        else $error("walk pipe active outside walk");
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_zero && (!o_m_tvalid || i_m_tready))
            |=> (o_m_tvalid && o_m_tuser && o_m_tdata == '0))
        else $error("zero weight result not cleared");
endmodule

// File: test/testbench.sv
// testbench for the weighted concordance fraction block: loads, queries, shares
`timescale 1ns / 1ps
module testbench;
    typedef struct packed {
        logic [wcf_pkg::FRAC_W-1:0] conc;
        logic [wcf_pkg::FRAC_W-1:0] disc;
        logic [wcf_pkg::FRAC_W-1:0] tied;
        logic                       no_weight;
    } t_shares;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [wcf_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [wcf_pkg::FUNC_W-1:0]     i_s_tuser = wcf_pkg::FUNC_NONE;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [wcf_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                           o_m_tuser;
    logic                           i_cfg_we = 1'b0;
    logic                           i_cfg_addr = wcf_pkg::REG_OBS_COUNT;
    logic [wcf_pkg::TOL_W-1:0]      i_cfg_wdata = '0;

    weighted_concordance_fractions dut (.*);

    always #5 i_clk = ~i_clk;

    // own copy of block state
    logic [wcf_pkg::GRP_W-1:0]  grp_mem [64];
    logic [wcf_pkg::WGT_W-1:0]  wgt_mem [64];
    logic [wcf_pkg::CODE_W-1:0] code_mem [64][64];
    bit                         grp_set [64];
    bit                         code_set [64][64];
    int unsigned                n_obs;
    logic [wcf_pkg::TOL_W-1:0]  tol_q;
    t_shares                    pending_shares [$];
    int                         errors = 0;
    int                         burst_left = 0;
    longint                     cycles = 0;

    function automatic logic [wcf_pkg::FRAC_W-1:0] frac(longint unsigned part,
                                                       longint unsigned tot);
        return wcf_pkg::FRAC_W'(((part << 16) + (tot >> 1)) / tot);
    endfunction

    function automatic t_shares row_shares(int unsigned row);
        longint unsigned c, d, t, tot, w;
        longint gi, gj, tol;
        logic [wcf_pkg::CODE_W-1:0] code;
        t_shares r;
        c = 0; d = 0; t = 0; tot = 0;
        gi = longint'($signed(grp_mem[row]));
        tol = longint'(tol_q);
        for (int j = 0; j < n_obs; j++) begin
            gj = longint'($signed(grp_mem[j]));
            w = wgt_mem[j];
            code = wcf_pkg::CODE_INV;
            if (gi > gj + tol) code = code_mem[row][j];
            else if (gj > gi + tol) code = code_mem[j][row];
            if (code == wcf_pkg::CODE_CONC) c += w;
            else if (code == wcf_pkg::CODE_DISC) d += w;
            else if (code == wcf_pkg::CODE_TIED) t += w;
            tot += w;
        end
        if (tot == 0) r = '{conc: '0, disc: '0, tied: '0, no_weight: 1'b1};
        else r = '{conc: frac(c, tot), disc: frac(d, tot), tied: frac(t, tot),
                   no_weight: 1'b0};
        return r;
    endfunction

    // a query is legal only if every store entry it touches has been written
    function automatic bit query_ok(int unsigned row);
        longint gi, gj, tol;
        if (n_obs == 0) return 1;
        if (!grp_set[row]) return 0;
        gi = longint'($signed(grp_mem[row]));
        tol = longint'(tol_q);
        for (int j = 0; j < n_obs; j++) begin
            if (!grp_set[j]) return 0;
            gj = longint'($signed(grp_mem[j]));
            if (gi > gj + tol && !code_set[row][j]) return 0;
            if (gj > gi + tol && !code_set[j][row]) return 0;
        end
        return 1;
    endfunction

    task automatic send_item(wcf_pkg::t_func f, int unsigned a, int unsigned b,
                             logic [wcf_pkg::GRP_W-1:0] g, logic [wcf_pkg::WGT_W-1:0] w,
                             logic [wcf_pkg::CODE_W-1:0] pc);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= f;
        i_s_tdata <= {2'b0, pc, w, g, b[5:0], a[5:0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        case (f)
            wcf_pkg::FUNC_LOAD_OBS: begin
                grp_mem[a] = g; wgt_mem[a] = w; grp_set[a] = 1;
            end
            wcf_pkg::FUNC_LOAD_CODE: begin
                code_mem[a][b] = pc; code_set[a][b] = 1;
            end
            wcf_pkg::FUNC_QUERY: pending_shares.push_back(row_shares(a));
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_shares.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(logic addr, logic [wcf_pkg::TOL_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == wcf_pkg::REG_OBS_COUNT) n_obs = (val[6:0] > 64) ? 64 : val[6:0];
        else tol_q = val;
    endtask

    function automatic logic [wcf_pkg::GRP_W-1:0] rand_grp();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return wcf_pkg::GRP_W'($urandom_range(0, 7) << 16);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [wcf_pkg::WGT_W-1:0] rand_wgt();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 24'hff_ffff;
            default: return wcf_pkg::WGT_W'($urandom());
        endcase
    endfunction

    task automatic load_all(int unsigned n, bit zero_w);
        for (int i = 0; i < n; i++)
            send_item(wcf_pkg::FUNC_LOAD_OBS, i, $urandom_range(0, 63), rand_grp(),
                      zero_w ? '0 : rand_wgt(), wcf_pkg::CODE_W'($urandom()));
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                send_item(wcf_pkg::FUNC_LOAD_CODE, i, j, $urandom(),
                          wcf_pkg::WGT_W'($urandom()), wcf_pkg::CODE_W'($urandom()));
    endtask

    task automatic test_directed();
        // small set, all four codes, the extreme scores and weights
        send_item(wcf_pkg::FUNC_LOAD_OBS, 0, 63, 32'h8000_0000, 24'hff_ffff, wcf_pkg::CODE_INV);
        send_item(wcf_pkg::FUNC_LOAD_OBS, 1, 0, 32'h7fff_ffff, 24'h00_0001, wcf_pkg::CODE_INV);
        send_item(wcf_pkg::FUNC_LOAD_OBS, 2, 0, 32'h0000_0000, 24'h00_0000, wcf_pkg::CODE_INV);
        send_item(wcf_pkg::FUNC_LOAD_OBS, 3, 0, 32'h0001_0000, 24'h01_0000, wcf_pkg::CODE_INV);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_item(wcf_pkg::FUNC_LOAD_CODE, i, j, '1, '1,
                          wcf_pkg::CODE_W'((i + j) % 4));
        send_item(wcf_pkg::FUNC_QUERY, 0, 0, '0, '0, wcf_pkg::CODE_DISC);
        drain();
        write_reg(wcf_pkg::REG_OBS_COUNT, 4);
        // row outside the used range, with every entry it touches loaded
        send_item(wcf_pkg::FUNC_LOAD_OBS, 63, 0, 32'h0000_0000, 24'h00_8000, wcf_pkg::CODE_INV);
        send_item(wcf_pkg::FUNC_LOAD_CODE, 63, 0, '0, '0, wcf_pkg::CODE_CONC);
        send_item(wcf_pkg::FUNC_LOAD_CODE, 1, 63, '0, '0, wcf_pkg::CODE_TIED);
        send_item(wcf_pkg::FUNC_LOAD_CODE, 3, 63, '0, '0, wcf_pkg::CODE_DISC);
        for (int r = 0; r < 4; r++)
            send_item(wcf_pkg::FUNC_QUERY, r, 0, '0, '0, wcf_pkg::CODE_DISC);
        send_item(wcf_pkg::FUNC_QUERY, 63, 0, '0, '0, wcf_pkg::CODE_DISC);
        send_item(wcf_pkg::FUNC_NONE, 5, 5, '1, '1, wcf_pkg::CODE_INV);
        drain();
        write_reg(wcf_pkg::REG_TOLERANCE, 31'h7fff_ffff);
        send_item(wcf_pkg::FUNC_QUERY, 1, 0, '0, '0, wcf_pkg::CODE_DISC);
        drain();
        write_reg(wcf_pkg::REG_OBS_COUNT, 0);
        send_item(wcf_pkg::FUNC_QUERY, 1, 0, '0, '0, wcf_pkg::CODE_DISC);
        drain();
        write_reg(wcf_pkg::REG_OBS_COUNT, 127);
        write_reg(wcf_pkg::REG_TOLERANCE, 0);
        drain();
    endtask

    task automatic test_random(int unsigned n, bit zero_w, int unsigned items);
        int unsigned row, sent;
        write_reg(wcf_pkg::REG_OBS_COUNT, n);
        write_reg(wcf_pkg::REG_TOLERANCE, wcf_pkg::TOL_W'($urandom_range(0, 1) ?
                  $urandom_range(0, 3) << 16 : $urandom()));
        load_all(n, zero_w);
        sent = n + n * n;
        while (sent < items) begin
            case ($urandom_range(0, 9))
                0: send_item(wcf_pkg::FUNC_LOAD_OBS, $urandom_range(0, n - 1), $urandom(),
                             rand_grp(), zero_w ? '0 : rand_wgt(),
                             wcf_pkg::CODE_W'($urandom()));
                1, 2: send_item(wcf_pkg::FUNC_LOAD_CODE, $urandom_range(0, n - 1),
                                $urandom_range(0, n - 1), $urandom(),
                                wcf_pkg::WGT_W'($urandom()), wcf_pkg::CODE_W'($urandom()));
                3: send_item(wcf_pkg::FUNC_NONE, $urandom(), $urandom(), $urandom(),
                             wcf_pkg::WGT_W'($urandom()), wcf_pkg::CODE_W'($urandom()));
                default: begin
                    row = $urandom_range(0, 63);
                    if (!query_ok(row)) row = $urandom_range(0, n - 1);
                    send_item(wcf_pkg::FUNC_QUERY, row, $urandom(), $urandom(),
                              wcf_pkg::WGT_W'($urandom()), wcf_pkg::CODE_W'($urandom()));
                end
            endcase
            sent++;
        end
        drain();
    endtask

    // every observation in use; only pairs with the most negative score carry a code
    task automatic test_full_walk(int unsigned queries);
        int unsigned row;
        write_reg(wcf_pkg::REG_OBS_COUNT, 64);
        write_reg(wcf_pkg::REG_TOLERANCE, 31'h7fff_ffff);
        send_item(wcf_pkg::FUNC_LOAD_OBS, 0, 0, 32'h8000_0000, rand_wgt(), wcf_pkg::CODE_INV);
        for (int j = 1; j < 64; j++)
            send_item(wcf_pkg::FUNC_LOAD_OBS, j, 0, {1'b0, 31'($urandom())}, rand_wgt(),
                      wcf_pkg::CODE_INV);
        for (int j = 0; j < 64; j++)
            send_item(wcf_pkg::FUNC_LOAD_CODE, j, 0, '0, '0, wcf_pkg::CODE_W'($urandom()));
        for (int q = 0; q < queries; q++) begin
            row = $urandom_range(0, 63);
            if (!query_ok(row)) row = 0;
            send_item(wcf_pkg::FUNC_QUERY, row, 0, '0, '0, wcf_pkg::CODE_DISC);
        end
        drain();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_shares got, exp_s;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{conc: o_m_tdata[16:0], disc: o_m_tdata[33:17],
                    tied: o_m_tdata[50:34], no_weight: o_m_tuser};
            if (pending_shares.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_s = pending_shares.pop_front();
                if (got.conc !== exp_s.conc || got.disc !== exp_s.disc ||
                    got.tied !== exp_s.tied || got.no_weight !== exp_s.no_weight) begin
                    $display("%0t mismatch expected c=%0d d=%0d t=%0d z=%0d %s",
                             $time, exp_s.conc, exp_s.disc, exp_s.tied, exp_s.no_weight,
                             $sformatf("actual c=%0d d=%0d t=%0d z=%0d",
                                       got.conc, got.disc, got.tied, got.no_weight));
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if ((cycles / 300) % 3 == 0) i_m_tready <= 1'b1;
        else i_m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        n_obs = 1;
        tol_q = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(2, 0, 80);
        test_random(8, 0, 400);
        test_random(3, 1, 60);
        test_random(16, 0, 900);
        test_full_walk(100);
        if (pending_shares.size() != 0) begin
            $display("%0t %0d results missing", $time, pending_shares.size());
            errors++;
        end
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        wait (cycles > 3000000);
        $display("status: fail");
        $finish;
    end
endmodule

// File: weighted_concordance_fractions.f
src/wcf_pkg.sv
src/wcf_mem.sv
src/wcf_div.sv
src/weighted_concordance_fractions.sv
test/testbench.sv
